### rtl/core/ipv6_address_compressor_assert.svh
// Assertion macros shared by the address compressor RTL.
// No dependencies; included by the modules that carry checks.
`ifndef IPV6_ADDRESS_COMPRESSOR_ASSERT_SVH
`define IPV6_ADDRESS_COMPRESSOR_ASSERT_SVH
`ifndef SYNTHESIS
// Check that a property holds on every clock edge outside reset
`define IPV6C_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ipv6c assertion failed");
// Check that a condition never occurs outside reset
`define IPV6C_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ipv6c forbidden condition seen");
`else
`define IPV6C_ASSERT(label, clk, rst, prop)
`define IPV6C_NEVER(label, clk, rst, cond)
`endif
`endif

### rtl/core/ipv6c_pkg.sv
// Types, character codes and helper functions for the address compressor.
// No dependencies; imported by every module of the block.
`default_nettype none

package ipv6c_pkg;

   localparam int unsigned NumGroups = 8;

   localparam logic [6:0] CHAR_COLON     = 7'd58;
   localparam logic [6:0] CHAR_ZERO      = 7'd48;
   localparam logic [6:0] CHAR_NINE      = 7'd57;
   localparam logic [6:0] CHAR_LOWER_A   = 7'd97;
   localparam logic [6:0] CHAR_LOWER_F   = 7'd102;
   // 'a' minus ten, so that a digit of ten or more maps onto 'a'..'f'
   localparam logic [6:0] HEX_ALPHA_BASE = 7'd87;

   // One input item: the address in two halves
   typedef struct packed {
      logic [63:0] addr_upper;
      logic [63:0] addr_lower;
   } req_type;

   // One result item: a single character of the text
   typedef struct packed {
      logic [6:0] text_char;
      logic       last_char;
   } rsp_type;

   // Classified address handed from the front end to the emitter
   typedef struct packed {
      logic [NumGroups-1:0][15:0] groups;
      logic [2:0]                 run_start;
      logic [3:0]                 run_length;
   } job_type;

   // Map a nibble onto its lowercase hex character
   function automatic logic [6:0] hex_char(input logic [3:0] value);
      logic [6:0] base;
      base = (value < 4'd10) ? CHAR_ZERO : HEX_ALPHA_BASE;
      return base + {3'b000, value};
   endfunction

   // Index of the highest nonzero nibble, zero for a zero group
   function automatic logic [1:0] top_nibble(input logic [15:0] grp);
      logic [1:0] top;
      top = 2'd0;
      for (int k = 1; k < 4; k++) begin
         if (grp[4*k +: 4] != 4'd0) begin
            top = 2'(k);
         end
      end
      return top;
   endfunction

endpackage

`default_nettype wire

### rtl/core/ipv6c_front.sv
// Front end: splits an address into groups and finds the longest zero run.
// Depends on ipv6c_pkg.
`default_nettype none

module ipv6c_front (
   input  ipv6c_pkg::req_type req_data,
   output ipv6c_pkg::job_type job_out
);
   import ipv6c_pkg::*;

   logic [NumGroups-1:0][15:0] groups;
   logic [3:0]                 cur_len;
   logic [2:0]                 cur_start;
   logic [3:0]                 best_len;
   logic [2:0]                 best_start;

   // Split: group 0 sits in the top bits of the upper half
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         groups[i]     = req_data.addr_upper[48 - 16*i +: 16];
         groups[4 + i] = req_data.addr_lower[48 - 16*i +: 16];
      end
   end

   // Scan for the longest zero run; a strictly longer run replaces the first
   always_comb begin
      cur_len    = 4'd0;
      cur_start  = 3'd0;
      best_len   = 4'd0;
      best_start = 3'd0;
      for (int i = 0; i < NumGroups; i++) begin
         if (groups[i] == 16'd0) begin
            if (cur_len == 4'd0) begin
               cur_start = 3'(i);
            end
            cur_len = cur_len + 4'd1;
            if (cur_len > best_len) begin
               best_len   = cur_len;
               best_start = cur_start;
            end
         end else begin
            cur_len = 4'd0;
         end
      end
   end

   assign job_out.groups     = groups;
   assign job_out.run_start  = best_start;
   assign job_out.run_length = best_len;

endmodule

`default_nettype wire

### rtl/core/ipv6c_queue.sv
// Short queue of classified addresses between the front end and the emitter.
// Depends on ipv6c_pkg and the assertion macro header.
`default_nettype none
`include "ipv6_address_compressor_assert.svh"

module ipv6c_queue #(
   parameter int unsigned DEPTH = 2   // two or more entries
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ipv6c_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output ipv6c_pkg::job_type pop_data
);
   import ipv6c_pkg::*;

   localparam int unsigned PtrW = $clog2(DEPTH);
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   job_type         entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full     = (count_ff == CntW'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `IPV6C_NEVER(a_q_count_range, clock, reset, count_ff > CntW'(DEPTH))
   `IPV6C_ASSERT(a_q_empty_ptrs, clock, reset, (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
   `IPV6C_ASSERT(a_q_full_ptrs, clock, reset, full |-> (rd_ptr_ff == wr_ptr_ff))

endmodule

`default_nettype wire

### rtl/core/ipv6c_emit.sv
// Back end: walks the groups of one address and produces one character per
// step into an output register. Depends on ipv6c_pkg and the macro header.
`default_nettype none
`include "ipv6_address_compressor_assert.svh"

module ipv6c_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  ipv6c_pkg::job_type job_data,
   output logic              job_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output ipv6c_pkg::rsp_type rsp_data
);
   import ipv6c_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,     // waiting for a classified address
      ST_BOUND,    // at the start of a group
      ST_DCOLON,   // second colon of the zero run
      ST_DIGIT     // inside the digits of a group
   } state_type;

   state_type  state_ff, state_in;
   job_type    job_ff, job_in;
   logic [3:0] group_ff, group_in;
   logic [1:0] nibble_ff, nibble_in;
   logic       need_colon_ff, need_colon_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic [15:0] cur_group;
   logic [1:0]  top;
   logic [1:0]  digit_nib;
   logic        run_hit;
   logic        can_step;
   logic        emit;
   logic [6:0]  emit_char;
   logic        emit_last;
   logic [3:0]  group_next;
   logic [3:0]  run_end;
   logic        char_legal;

   assign cur_group = job_ff.groups[group_ff[2:0]];
   assign top       = top_nibble(cur_group);
   assign digit_nib = (state_ff == ST_BOUND) ? top : nibble_ff;
   assign run_hit   = (job_ff.run_length != 4'd0) && (group_ff == {1'b0, job_ff.run_start});
   assign can_step  = !rsp_valid_ff || rsp_pop;
   assign group_next = group_ff + 4'd1;
   assign run_end    = group_ff + job_ff.run_length;

   // Sequence one character per step; hold while the output register is blocked
   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      group_in      = group_ff;
      nibble_in     = nibble_ff;
      need_colon_in = need_colon_ff;
      job_pop       = 1'b0;
      emit          = 1'b0;
      emit_char     = CHAR_COLON;
      emit_last     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop       = 1'b1;
               job_in        = job_data;
               group_in      = 4'd0;
               nibble_in     = 2'd0;
               need_colon_in = 1'b0;
               state_in      = ST_BOUND;
            end
         end
         ST_DCOLON: begin
            if (can_step) begin
               emit          = 1'b1;
               emit_last     = (run_end == 4'(NumGroups));
               group_in      = run_end;
               need_colon_in = 1'b0;
               state_in      = emit_last ? ST_IDLE : ST_BOUND;
            end
         end
         ST_BOUND, ST_DIGIT: begin
            if (can_step) begin
               emit = 1'b1;
               if (state_ff == ST_BOUND && run_hit) begin
                  state_in = ST_DCOLON;
               end else if (state_ff == ST_BOUND && need_colon_ff) begin
                  nibble_in = top;
                  state_in  = ST_DIGIT;
               end else begin
                  emit_char = hex_char(cur_group[4*digit_nib +: 4]);
                  if (digit_nib == 2'd0) begin
                     emit_last     = (group_next == 4'(NumGroups));
                     group_in      = group_next;
                     need_colon_in = 1'b1;
                     state_in      = emit_last ? ST_IDLE : ST_BOUND;
                  end else begin
                     nibble_in = digit_nib - 2'd1;
                     state_in  = ST_DIGIT;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Load the output register on emit, drop it on transfer
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_in.text_char = emit_char;
         rsp_in.last_char = emit_last;
         rsp_valid_in     = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and output register; payload registers carry no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         group_ff      <= 4'd0;
         nibble_ff     <= 2'd0;
         need_colon_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         group_ff      <= group_in;
         nibble_ff     <= nibble_in;
         need_colon_ff <= need_colon_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Legal text characters: colon, decimal digits and lowercase hex letters
   assign char_legal = rsp_ff.text_char inside
      {CHAR_COLON, [CHAR_ZERO:CHAR_NINE], [CHAR_LOWER_A:CHAR_LOWER_F]};

   `IPV6C_ASSERT(a_em_group_range, clock, reset, (state_ff != ST_IDLE) |-> (group_ff < 4'(NumGroups)))
   `IPV6C_ASSERT(a_em_last_idle, clock, reset, (emit && emit_last) |=> (state_ff == ST_IDLE))
   `IPV6C_ASSERT(a_em_char_legal, clock, reset, rsp_valid_ff |-> char_legal)

endmodule

`default_nettype wire

### rtl/core/ipv6_address_compressor.sv
// Address compressor top level: streams the compressed text of 128-bit
// addresses, one ASCII character per result item.
//
// Input channel: present an address on req_data and raise req_push; it is
// transferred at a clock edge with req_push high and req_full low.
// Result channel: while rsp_empty is low, rsp_data holds the oldest waiting
// character; it is transferred at an edge with rsp_pop high. last_char marks
// the final character of each address text.
// On its way to rsp_data, the first character of an address passes the queue,
// the emitter's job register and the output register when the emitter is free.
// Throughput: one character per cycle while the receiver keeps rsp_pop high,
// with a load of the emitter from the queue between addresses. The
// one-character-per-cycle emitter sets this figure; the front end
// classifies combinationally and a QUEUE_DEPTH-entry queue buffers
// addresses ahead of the emitter.
// Reset (synchronous, active high) empties the queue and the output
// register. When the receiver stalls, the current character holds and the
// emitter waits; new addresses are taken until the queue fills.
// Depends on ipv6c_pkg, ipv6c_front, ipv6c_queue and ipv6c_emit.
`default_nettype none

module ipv6_address_compressor #(
   parameter int unsigned QUEUE_DEPTH = 2   // two or more entries
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  ipv6c_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output ipv6c_pkg::rsp_type rsp_data
);
   import ipv6c_pkg::*;

   job_type front_job;
   job_type queue_job;
   logic    queue_valid;
   logic    queue_pop;

   // Classify the incoming address
   ipv6c_front u_front (
      .req_data (req_data),
      .job_out  (front_job)
   );

   // Buffer classified addresses
   ipv6c_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_job),
      .full      (req_full),
      .pop       (queue_pop),
      .valid     (queue_valid),
      .pop_data  (queue_job)
   );

   // Produce the text
   ipv6c_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_valid),
      .job_data  (queue_job),
      .job_pop   (queue_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
